>>> design/ccp_pkg.sv
`default_nettype none

package ccp_pkg;

	// parse phases
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_TAG    = 3'd1;
	localparam logic [2:0] PH_FIELDS = 3'd2;
	localparam logic [2:0] PH_TEXT   = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;

	// constant pool tags
	localparam logic [7:0] TAG_UTF8      = 8'd1;
	localparam logic [7:0] TAG_INTEGER   = 8'd3;
	localparam logic [7:0] TAG_FLOAT     = 8'd4;
	localparam logic [7:0] TAG_LONG      = 8'd5;
	localparam logic [7:0] TAG_DOUBLE    = 8'd6;
	localparam logic [7:0] TAG_CLASS     = 8'd7;
	localparam logic [7:0] TAG_STRING    = 8'd8;
	localparam logic [7:0] TAG_FIELDREF  = 8'd9;
	localparam logic [7:0] TAG_METHREF   = 8'd10;
	localparam logic [7:0] TAG_IFMETHREF = 8'd11;
	localparam logic [7:0] TAG_NAMETYPE  = 8'd12;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef struct packed {
		logic [7:0] pool_byte;
		logic       start_req;
	} ccp_in_t;

	typedef struct packed {
		logic [15:0] entry_index;
		logic [7:0]  entry_tag;
		logic [31:0] value_a;
		logic [15:0] value_b;
		logic [31:0] text_offset;
		logic        status;
		logic        last;
		logic [31:0] bytes_used;
	} ccp_out_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [15:0] slot_index;
		logic [7:0]  current_tag;
		logic [3:0]  field_byte_count;
		logic [31:0] gather_word;
		logic [15:0] second_word;
		logic [15:0] text_remaining;
		logic [31:0] byte_offset;
	} ccp_state_t;

	// payload bytes after the tag; zero marks an unknown tag
	function automatic logic [3:0] payload_len(input logic [7:0] tag);
		logic [3:0] n;
		unique case (tag)
			TAG_UTF8, TAG_CLASS, TAG_STRING: n = 4'd2;
			TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHREF,
			TAG_IFMETHREF, TAG_NAMETYPE: n = 4'd4;
			TAG_LONG, TAG_DOUBLE: n = 4'd8;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

>>> design/ccp_step.sv
`default_nettype none

// One byte of parse: next state and the optional result.
module ccp_step (
	input  wire ccp_pkg::ccp_state_t cur,
	input  wire ccp_pkg::ccp_in_t    item,
	input  wire logic [15:0]         pool_count,
	output ccp_pkg::ccp_state_t      nxt,
	output logic                     emit,
	output ccp_pkg::ccp_out_t        res
);

	always_comb begin
		logic        active;
		logic        finish;
		logic [3:0]  n;
		logic [16:0] next_slot;
		logic        is_last;
		logic [31:0] a;
		logic [15:0] b;
		logic [31:0] toff;
		logic [1:0]  step;

		nxt    = cur;
		emit   = 1'b0;
		res    = '0;
		finish = 1'b0;
		active = (cur.phase == ccp_pkg::PH_TAG) || (cur.phase == ccp_pkg::PH_FIELDS) ||
			(cur.phase == ccp_pkg::PH_TEXT);
		n         = ccp_pkg::payload_len(item.pool_byte);
		a         = '0;
		b         = '0;
		toff      = '0;
		step      = 2'd1;
		next_slot = '0;
		is_last   = 1'b0;

		if (item.start_req) begin
			nxt.byte_offset      = '0;
			nxt.slot_index       = 16'd1;
			nxt.text_remaining   = '0;
			nxt.field_byte_count = '0;
			if (pool_count <= 16'd1) begin
				nxt.phase = ccp_pkg::PH_DONE;
				active    = 1'b0;
			end else begin
				nxt.phase = ccp_pkg::PH_TAG;
				active    = 1'b1;
			end
		end

		if (active) begin
			nxt.byte_offset = nxt.byte_offset + 32'd1;
			unique case (nxt.phase)
				ccp_pkg::PH_TAG: begin
					nxt.current_tag = item.pool_byte;
					nxt.gather_word = '0;
					nxt.second_word = '0;
					if (n == 4'd0) begin
						emit            = 1'b1;
						res.entry_index = nxt.slot_index;
						res.entry_tag   = item.pool_byte;
						res.status      = ccp_pkg::STATUS_ERR;
						res.last        = 1'b1;
						res.bytes_used  = nxt.byte_offset;
						nxt.phase       = ccp_pkg::PH_DONE;
					end else begin
						nxt.field_byte_count = n;
						nxt.phase            = ccp_pkg::PH_FIELDS;
					end
				end
				ccp_pkg::PH_FIELDS: begin
					nxt.gather_word      = {nxt.gather_word[23:0], item.pool_byte};
					nxt.field_byte_count = nxt.field_byte_count - 4'd1;
					if (nxt.field_byte_count == 4'd0) begin
						if (nxt.current_tag == ccp_pkg::TAG_UTF8) begin
							nxt.second_word = nxt.gather_word[15:0];
						end
						if (nxt.current_tag == ccp_pkg::TAG_UTF8 &&
							nxt.gather_word[15:0] != 16'd0) begin
							nxt.text_remaining = nxt.gather_word[15:0];
							nxt.phase          = ccp_pkg::PH_TEXT;
						end else begin
							finish = 1'b1;
						end
					end
				end
				default: begin
					// text bytes are skipped
					nxt.text_remaining = nxt.text_remaining - 16'd1;
					finish             = (nxt.text_remaining == 16'd0);
				end
			endcase
		end

		if (finish) begin
			priority if (nxt.current_tag == ccp_pkg::TAG_UTF8) begin
				a    = {16'd0, nxt.second_word};
				toff = nxt.byte_offset - {16'd0, nxt.second_word};
			end else if (nxt.current_tag == ccp_pkg::TAG_LONG ||
				nxt.current_tag == ccp_pkg::TAG_DOUBLE) begin
				step = 2'd2;
			end else if (nxt.current_tag == ccp_pkg::TAG_CLASS ||
				nxt.current_tag == ccp_pkg::TAG_STRING) begin
				a = {16'd0, nxt.gather_word[15:0]};
			end else if (nxt.current_tag == ccp_pkg::TAG_INTEGER ||
				nxt.current_tag == ccp_pkg::TAG_FLOAT) begin
				a = nxt.gather_word;
			end else begin
				a = {16'd0, nxt.gather_word[31:16]};
				b = nxt.gather_word[15:0];
			end
			next_slot       = {1'b0, nxt.slot_index} + {15'd0, step};
			is_last         = next_slot >= {1'b0, pool_count};
			emit            = 1'b1;
			res.entry_index = nxt.slot_index;
			res.entry_tag   = nxt.current_tag;
			res.value_a     = a;
			res.value_b     = b;
			res.text_offset = toff;
			res.status      = ccp_pkg::STATUS_OK;
			res.last        = is_last;
			res.bytes_used  = nxt.byte_offset;
			nxt.slot_index  = next_slot[15:0];
			nxt.phase       = is_last ? ccp_pkg::PH_DONE : ccp_pkg::PH_TAG;
		end
	end

endmodule

`default_nettype wire

>>> design/class_constant_pool_parser_unit.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// in        to block   in_valid / in_stall   ccp_in_t  (pool_byte, start_req)
// out       from block out_valid / out_stall ccp_out_t (one per entry or error)
// cfg       to block   cfg_we                cfg_wdata (pool_count)
//
// One byte per cycle sustained while out is not stalled. A byte is held in the
// input register, then the parse step updates the state and loads the result
// register, which drives out.
// The input register only advances when the result register is empty or is
// being taken this cycle; a stall on out reaches in_stall in the same cycle.
// Reset clears parse state to idle, slot 1, and pool_count to zero.
module class_constant_pool_parser_unit (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_we,
	input  wire [15:0]        cfg_wdata,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire ccp_pkg::ccp_in_t in_data,
	output logic              out_valid,
	input  wire               out_stall,
	output ccp_pkg::ccp_out_t out_data
);

	logic [15:0]         pool_count_q;
	logic                valid_s1;
	ccp_pkg::ccp_in_t    item_s1;
	ccp_pkg::ccp_state_t state_q;
	ccp_pkg::ccp_state_t state_nxt;
	logic                emit;
	ccp_pkg::ccp_out_t   res;
	logic                out_valid_q;
	ccp_pkg::ccp_out_t   out_data_q;
	logic                advance;
	logic                accept;

	// the staged byte is processed whenever the result slot is free or being taken
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_count_q <= '0;
		end else if (cfg_we) begin
			pool_count_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
	end

	ccp_step u_step (
		.cur        (state_q),
		.item       (item_s1),
		.pool_count (pool_count_q),
		.nxt        (state_nxt),
		.emit       (emit),
		.res        (res)
	);

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase            <= ccp_pkg::PH_IDLE;
			state_q.slot_index       <= 16'd1;
			state_q.current_tag      <= '0;
			state_q.field_byte_count <= '0;
			state_q.gather_word      <= '0;
			state_q.second_word      <= '0;
			state_q.text_remaining   <= '0;
			state_q.byte_offset      <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_data_q <= res;
		end
	end

endmodule

`default_nettype wire
